// File: sv/pbba_pkg.sv
// Shared types, constants and a helper function for the bucket allocator.
package pbba_pkg;

   localparam int NUM_ARENAS  = 16;
   localparam int ARENA_BYTES = 65536;
   localparam int BUCKETS     = 12;
   localparam int MIN_SHIFT   = 5;
   localparam int HDR_BYTES   = 16;
   localparam int ADDR_BITS   = 20;
   localparam int IDX_BITS    = ADDR_BITS - MIN_SHIFT;
   localparam int ARENA_SHIFT = $clog2(ARENA_BYTES);
   localparam int ARENA_BITS  = $clog2(NUM_ARENAS);
   localparam int SLOT_BITS   = ARENA_SHIFT - MIN_SHIFT;
   localparam int ARENA_FIT   = (1 << ADDR_BITS) / ARENA_BYTES;
   localparam int USE_MAX     = (NUM_ARENAS < ARENA_FIT) ? NUM_ARENAS : ARENA_FIT;
   localparam int BKT_BITS    = 4;
   localparam int CNT_BITS    = $clog2(NUM_ARENAS + 1);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_LARGE   = 3'd2;
   localparam logic [2:0] ST_NOARENA = 3'd3;
   localparam logic [2:0] ST_NULL    = 3'd4;
   localparam logic [2:0] ST_BADADDR = 3'd5;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_DONE  = 2'd2;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      logic [1:0]          op;
      logic [2:0]          status;
      logic [BKT_BITS-1:0] bucket;
      logic [IDX_BITS-1:0] idx;
   } cmd_type;

   // Log2 size for a nonzero request: ceil(log2(size+16)); the caller clamps it and subtracts MIN_SHIFT.
   function automatic logic [5:0] size_log2(input logic [35:0] req);
      logic [36:0] m;
      logic [5:0]  lg;
      m  = {1'b0, req} + 37'(HDR_BYTES) - 37'd1;
      lg = 6'd0;
      for (int i = 0; i < 37; i++) begin
         if (m[i]) lg = 6'(i + 1);
      end
      return lg;
   endfunction

endpackage

// File: sv/pbba_front.sv
// Front part: accepts requests and classifies them into back-end commands.
module pbba_front import pbba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [35:0]           req_request_size,
   input  logic [19:0]           req_block_address,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd,
   output logic [ARENA_BITS-1:0] arena_rd,
   input  logic [BKT_BITS-1:0]   arena_bkt,
   input  logic [CNT_BITS-1:0]   arenas_used,
   input  logic                  back_idle
);
   logic        valid_ff, valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic [5:0]  lg;
   logic [19:0] hdr;
   logic [19:0] off;
   logic [19:0] mask;
   logic [BKT_BITS-1:0] bkt;
   logic        arena_ok;

   // hold new items until the back part has settled arena count and owners
   assign req_full  = valid_ff || !back_idle;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   assign hdr      = req_block_address - 20'(HDR_BYTES);
   assign arena_rd = ARENA_BITS'(hdr >> ARENA_SHIFT);
   assign off      = hdr & 20'(ARENA_BYTES - 1);
   assign arena_ok = (32'(hdr >> ARENA_SHIFT) < 32'(arenas_used))
                     && (32'(hdr >> ARENA_SHIFT) < NUM_ARENAS);
   assign bkt      = arena_bkt;
   assign mask     = (20'd1 << (5'(bkt) + 5'(MIN_SHIFT))) - 20'd1;

   always_comb begin
      lg = size_log2(req_request_size);
      if (lg < 6'(MIN_SHIFT)) lg = 6'(MIN_SHIFT);
      cmd_in = '0;
      cmd_in.idx = IDX_BITS'(hdr >> MIN_SHIFT);
      if (!req_func) begin
         if (req_request_size == '0) begin
            cmd_in.op = OP_DONE;
            cmd_in.status = ST_ZERO;
         end else if ((lg - 6'(MIN_SHIFT)) >= 6'(BUCKETS) || lg > 6'(ARENA_SHIFT)) begin
            cmd_in.op = OP_DONE;
            cmd_in.status = ST_LARGE;
         end else begin
            cmd_in.op = OP_ALLOC;
            cmd_in.bucket = BKT_BITS'(lg - 6'(MIN_SHIFT));
         end
      end else begin
         if (req_block_address == '0) begin
            cmd_in.op = OP_DONE;
            cmd_in.status = ST_NULL;
         end else if (req_block_address < 20'(HDR_BYTES) || !arena_ok
                      || bkt >= BKT_BITS'(BUCKETS) || (off & mask) != '0) begin
            cmd_in.op = OP_DONE;
            cmd_in.status = ST_BADADDR;
         end else begin
            cmd_in.op = OP_FREE;
            cmd_in.bucket = bkt;
         end
      end
   end

   assign valid_in = (req_push && !req_full) ? 1'b1 : (cmd_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (req_push && !req_full) cmd_ff <= cmd_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !cmd_ready |=> valid_ff && $stable(cmd_ff))
      else $error("front command dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && cmd_ff.op == OP_DONE |-> cmd_ff.status != ST_OK)
      else $error("finished command without error status");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && cmd_ff.op != OP_DONE |-> cmd_ff.bucket < BKT_BITS'(BUCKETS))
      else $error("bucket out of range");
endmodule

// File: sv/pbba_back.sv
// Back part: free-list memory, arena carving and result queue.
module pbba_back import pbba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            arena_limit,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   input  logic [ARENA_BITS-1:0] arena_rd,
   output logic [BKT_BITS-1:0]   arena_bkt,
   output logic [CNT_BITS-1:0]   arenas_used,
   output logic                  back_idle,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [19:0]           rsp_result_address,
   output logic [2:0]            rsp_status,
   output logic [3:0]            rsp_bucket_used
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CARVE = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   logic [IDX_BITS:0]   link_mem [2**IDX_BITS];
   logic [IDX_BITS-1:0] head_ff [BUCKETS];
   logic [BUCKETS-1:0]  nonempty_ff;
   logic [BKT_BITS-1:0] abkt_ff [NUM_ARENAS];
   logic [CNT_BITS-1:0] used_ff;
   logic [1:0]          state_ff;
   cmd_type             cur_ff;
   logic [SLOT_BITS:0]  k_ff;
   logic [IDX_BITS:0]   rd_ff;
   logic                out_valid_ff;
   logic [19:0]         out_addr_ff;
   logic [2:0]          out_st_ff;
   logic [3:0]          out_bkt_ff;
   logic [4:0]          lim;
   logic                out_free;
   logic                out_load;
   logic [SLOT_BITS:0]  nslots;
   logic [IDX_BITS-1:0] base_idx;
   logic [IDX_BITS-1:0] slot_idx;
   logic [IDX_BITS-1:0] rd_addr;

   assign lim       = (32'(arena_limit) > USE_MAX) ? 5'(USE_MAX) : arena_limit;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign back_idle = (state_ff == S_IDLE);
   assign arena_bkt = abkt_ff[arena_rd];
   assign arenas_used = used_ff;
   assign rsp_empty = !out_valid_ff;
   assign rsp_result_address = out_addr_ff;
   assign rsp_status = out_st_ff;
   assign rsp_bucket_used = out_bkt_ff;

   assign nslots   = (SLOT_BITS+1)'(1) << (SLOT_BITS'(SLOT_BITS) - SLOT_BITS'(cur_ff.bucket));
   assign base_idx = IDX_BITS'(32'(used_ff) << SLOT_BITS);
   assign slot_idx = base_idx | IDX_BITS'(32'(k_ff) << cur_ff.bucket);
   assign rd_addr  = (state_ff == S_IDLE) ? head_ff[cmd.bucket] : head_ff[cur_ff.bucket];

   always_comb begin
      out_load = 1'b0;
      if (state_ff == S_IDLE && cmd_valid && cmd_ready) begin
         if (cmd.op != OP_ALLOC) out_load = 1'b1;
         else if (!nonempty_ff[cmd.bucket] && 32'(used_ff) >= 32'(lim)) out_load = 1'b1;
      end else if (state_ff == S_READ && out_free) begin
         out_load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= link_mem[rd_addr];
      if (state_ff == S_CARVE) begin
         link_mem[slot_idx] <= (k_ff + 1'b1 < nslots)
            ? {1'b1, IDX_BITS'(slot_idx + (IDX_BITS'(1) << cur_ff.bucket))}
            : '0;
      end else if (cmd_valid && cmd_ready && cmd.op == OP_FREE) begin
         link_mem[cmd.idx] <= nonempty_ff[cmd.bucket]
            ? {1'b1, head_ff[cmd.bucket]} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load)     out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cur_ff <= cmd;
                  if (cmd.op == OP_DONE) begin
                     out_addr_ff  <= '0;
                     out_st_ff    <= cmd.status;
                     out_bkt_ff   <= '0;
                  end else if (cmd.op == OP_FREE) begin
                     head_ff[cmd.bucket]     <= cmd.idx;
                     nonempty_ff[cmd.bucket] <= 1'b1;
                     out_addr_ff  <= '0;
                     out_st_ff    <= ST_OK;
                     out_bkt_ff   <= cmd.bucket;
                  end else if (nonempty_ff[cmd.bucket]) begin
                     state_ff <= S_READ;
                  end else if (32'(used_ff) >= 32'(lim)) begin
                     out_addr_ff  <= '0;
                     out_st_ff    <= ST_NOARENA;
                     out_bkt_ff   <= cmd.bucket;
                  end else begin
                     k_ff     <= '0;
                     state_ff <= S_CARVE;
                  end
               end
            end
            S_CARVE: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 == nslots) begin
                  abkt_ff[used_ff[ARENA_BITS-1:0]] <= cur_ff.bucket;
                  head_ff[cur_ff.bucket]     <= base_idx;
                  nonempty_ff[cur_ff.bucket] <= 1'b1;
                  used_ff  <= used_ff + 1'b1;
                  // reload the new head, then pop it as a plain allocate
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: state_ff <= S_READ;
            S_READ: begin
               if (out_free) begin
                  if (rd_ff[IDX_BITS]) head_ff[cur_ff.bucket] <= rd_ff[IDX_BITS-1:0];
                  else nonempty_ff[cur_ff.bucket] <= 1'b0;
                  out_addr_ff  <= {head_ff[cur_ff.bucket], MIN_SHIFT'(0)} + 20'(HDR_BYTES);
                  out_st_ff    <= ST_OK;
                  out_bkt_ff   <= cur_ff.bucket;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= NUM_ARENAS)
      else $error("arena count overflow");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CARVE |-> !cmd_ready)
      else $error("accepted during carve");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_addr_ff))
      else $error("result lost");
endmodule

// File: sv/pow2_bucket_block_allocator_top.sv
// Top level of the power-of-two bucket block allocator.
// Errors, frees and out-of-arena requests are answered from S_IDLE; an allocate from a
// nonempty list passes through S_READ, and one that carves an arena passes through S_CARVE
// once per slot, then S_LOAD and S_READ. A new item waits until the front register is
// empty and the back part is idle, plus any result stall.
// Reset clears list valid bits, arena count and the queues; arena_limit goes to 16.
module pow2_bucket_block_allocator_top import pbba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [35:0] req_request_size,
   input  logic [19:0] req_block_address,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [19:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_bucket_used,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);
   logic [4:0]            limit_ff;
   logic                  cmd_valid, cmd_ready;
   cmd_type               cmd;
   logic [ARENA_BITS-1:0] arena_rd;
   logic [BKT_BITS-1:0]   arena_bkt;
   logic [CNT_BITS-1:0]   arenas_used;
   logic                  back_idle;

   always_ff @(posedge clock) begin
      if (reset)       limit_ff <= 5'd16;
      else if (csr_we) limit_ff <= csr_wdata;
   end

   pbba_front u_front (.*);

   pbba_back u_back (
      .clock, .reset, .arena_limit(limit_ff), .cmd_valid, .cmd_ready, .cmd,
      .arena_rd, .arena_bkt, .arenas_used, .back_idle, .rsp_empty, .rsp_pop,
      .rsp_result_address, .rsp_status, .rsp_bucket_used
   );
endmodule
